/* rtl/rte_pkg.sv */
package rte_pkg;

    // controller states, one-hot
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RTT  = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_EST  = 8'b0001_0000,
        S_DEV  = 8'b0010_0000,
        S_OUT  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input transfer, form wrapped difference
        logic rtt;       // round trip in ms, bump sample count
        logic mul;       // mean*(n-1) + sample, load divider
        logic div_step;  // one restoring divide step
        logic est;       // store mean, form estimate
        logic dev;       // form deviation
        logic emit;      // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being drained
    } t_status;

    // timestamp and field widths
    localparam int unsigned TS_W   = 20;
    localparam int unsigned RTT_W  = 10;
    localparam int unsigned TMO_W  = 13;
    localparam int unsigned Q_W    = 18;
    localparam int unsigned SDATA_W = 40;
    localparam int unsigned MDATA_W = 80;

    // wrap of the microsecond difference, signed 22-bit math
    localparam logic signed [21:0] WRAP_US  = 22'sd1000000;
    localparam logic signed [21:0] WRAP2_US = 22'sd2000000;

    // floor(x/1000) = (x * RECIP_1000) >> RECIP_SHIFT for any 20-bit x
    localparam int unsigned      RECIP_W     = 21;
    localparam logic [20:0]      RECIP_1000  = 21'd1073742;
    localparam int unsigned      RECIP_SHIFT = 30;
    localparam int unsigned      RPROD_W     = TS_W + RECIP_W;

    localparam logic [RTT_W-1:0] RTT_MAX = 10'd999;

endpackage

/* rtl/rte_ctrl.sv */
module rte_ctrl #(
    parameter int unsigned VAL_W = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  rte_pkg::t_status  i_status,
    output rte_pkg::t_cmd     o_cmd
);

    localparam int unsigned CNT_W = $clog2(VAL_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VAL_W - 1);

    rte_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;

    assign o_s_tready = (r_state == rte_pkg::S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            rte_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = rte_pkg::S_RTT;
                end
            end
            rte_pkg::S_RTT: begin
                o_cmd.rtt = 1'b1;
                n_state   = rte_pkg::S_MUL;
            end
            rte_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = LAST_STEP;
                n_state   = rte_pkg::S_DIV;
            end
            rte_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = rte_pkg::S_EST;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            rte_pkg::S_EST: begin
                o_cmd.est = 1'b1;
                n_state   = rte_pkg::S_DEV;
            end
            rte_pkg::S_DEV: begin
                o_cmd.dev = 1'b1;
                n_state   = rte_pkg::S_OUT;
            end
            rte_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = rte_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rte_pkg::S_IDLE;
            end
        endcase
    end

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rte_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // an accepted transfer always starts the round-trip step
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == rte_pkg::S_RTT))
        else $error("accepted transfer did not start processing");

    // divide steps count down one per cycle
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rte_pkg::S_DIV && r_cnt != '0) |=>
        (r_state == rte_pkg::S_DIV && r_cnt == $past(r_cnt) - 1'b1))
        else $error("divide step counter skipped");

    // a result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result loaded over a pending result");

endmodule

/* rtl/rte_dpath.sv */
module rte_dpath #(
    parameter int unsigned COUNT_BITS = 32,
    parameter int unsigned FRAC_BITS  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rte_pkg::t_cmd                 i_cmd,
    output rte_pkg::t_status              o_status,
    input  logic [rte_pkg::SDATA_W-1:0]   i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rte_pkg::MDATA_W-1:0]   o_m_tdata
);

    localparam int unsigned VAL_W = rte_pkg::RTT_W + FRAC_BITS;
    localparam int unsigned SUM_W = VAL_W + COUNT_BITS;
    localparam int unsigned EXT_W = VAL_W + rte_pkg::Q_W;
    localparam logic [VAL_W-1:0] MEAN_MAX = VAL_W'({rte_pkg::RTT_MAX, {FRAC_BITS{1'b0}}});

    logic [rte_pkg::TS_W-1:0]  r_diff_us;
    logic [rte_pkg::RTT_W-1:0] r_rtt;
    logic [COUNT_BITS-1:0]     r_count;
    logic [COUNT_BITS-1:0]     r_rem;
    logic [VAL_W-1:0]          r_lo;
    logic [VAL_W-1:0]          r_mean, r_est, r_dev;

    logic                      r_out_valid;
    logic [rte_pkg::RTT_W-1:0] r_out_rtt;
    logic [rte_pkg::TMO_W-1:0] r_out_tmo;
    logic [rte_pkg::Q_W-1:0]   r_out_est, r_out_dev, r_out_mean;

    // microsecond difference with wrap
    logic signed [21:0] send_s, recv_s, diff_s, wrap_s;
    assign send_s = $signed({2'b00, i_s_tdata[rte_pkg::TS_W-1:0]});
    assign recv_s = $signed({2'b00, i_s_tdata[2*rte_pkg::TS_W-1:rte_pkg::TS_W]});
    assign diff_s = recv_s - send_s;
    always_comb begin
        if (diff_s < -rte_pkg::WRAP_US) begin
            wrap_s = diff_s + rte_pkg::WRAP2_US;
        end else if (diff_s < 22'sd0) begin
            wrap_s = diff_s + rte_pkg::WRAP_US;
        end else begin
            wrap_s = diff_s;
        end
    end

    // divide by 1000 through the reciprocal, saturate at 999 ms
    logic [rte_pkg::RPROD_W-1:0] rprod;
    logic [rte_pkg::RPROD_W-rte_pkg::RECIP_SHIFT-1:0] rtt_q;
    logic [rte_pkg::RTT_W-1:0] rtt_sat;
    assign rprod   = {{rte_pkg::RECIP_W{1'b0}}, r_diff_us} *
                     {{rte_pkg::TS_W{1'b0}}, rte_pkg::RECIP_1000};
    assign rtt_q   = rprod[rte_pkg::RPROD_W-1:rte_pkg::RECIP_SHIFT];
    assign rtt_sat = (rtt_q > {1'b0, rte_pkg::RTT_MAX}) ? rte_pkg::RTT_MAX
                                                       : rtt_q[rte_pkg::RTT_W-1:0];

    // sample in fixed point
    logic [VAL_W-1:0] sq;
    assign sq = {r_rtt, {FRAC_BITS{1'b0}}};

    // running sum mean*(n-1) + sample
    logic [COUNT_BITS-1:0] nm1;
    logic [SUM_W-1:0]      prod, sum;
    assign nm1  = r_count - 1'b1;
    assign prod = {{COUNT_BITS{1'b0}}, r_mean} * {{VAL_W{1'b0}}, nm1};
    assign sum  = prod + {{COUNT_BITS{1'b0}}, sq};

    // restoring divide step; remainder stays below n
    logic [COUNT_BITS:0] trial;
    logic                q_bit;
    assign trial = {r_rem, r_lo[VAL_W-1]};
    assign q_bit = (trial >= {1'b0, r_count});

    // estimate from the new mean and the sample
    logic [VAL_W+2:0] est_sum;
    assign est_sum = {r_lo, 3'b000} - {3'b000, r_lo} + {3'b000, sq};

    // deviation update
    logic [VAL_W-1:0] abs_err;
    logic [VAL_W+2:0] dev_sum;
    assign abs_err = (sq >= r_est) ? (sq - r_est) : (r_est - sq);
    assign dev_sum = {r_dev, 3'b000} - {3'b000, r_dev} + {3'b000, abs_err};

    // timeout = 4*dev + est, whole ms
    logic [VAL_W+2:0] tmo_sum;
    assign tmo_sum = {1'b0, r_dev, 2'b00} + {3'b000, r_est};

    // outputs cut to the 18-bit fields
    logic [EXT_W-1:0] est_ext, dev_ext, mean_ext;
    assign est_ext  = {{rte_pkg::Q_W{1'b0}}, r_est};
    assign dev_ext  = {{rte_pkg::Q_W{1'b0}}, r_dev};
    assign mean_ext = {{rte_pkg::Q_W{1'b0}}, r_mean};

    // estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mean  <= '0;
            r_est   <= '0;
            r_dev   <= '0;
        end else begin
            if (i_cmd.rtt && r_count != '1) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.est) begin
                r_mean <= r_lo;
                r_est  <= est_sum[VAL_W+2:3];
            end
            if (i_cmd.dev) begin
                r_dev <= dev_sum[VAL_W+2:3];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_diff_us <= wrap_s[rte_pkg::TS_W-1:0];
        end
        if (i_cmd.rtt) begin
            r_rtt <= rtt_sat;
        end
        if (i_cmd.mul) begin
            r_rem <= sum[SUM_W-1:VAL_W];
            r_lo  <= sum[VAL_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? (trial[COUNT_BITS-1:0] - r_count) : trial[COUNT_BITS-1:0];
            r_lo  <= {r_lo[VAL_W-2:0], q_bit};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_rtt  <= r_rtt;
            r_out_tmo  <= tmo_sum[VAL_W+2:FRAC_BITS];
            r_out_est  <= est_ext[rte_pkg::Q_W-1:0];
            r_out_dev  <= dev_ext[rte_pkg::Q_W-1:0];
            r_out_mean <= mean_ext[rte_pkg::Q_W-1:0];
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_mean, r_out_dev, r_out_est, r_out_tmo, r_out_rtt};

    // divider remainder never reaches the divisor
    a_rem_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_count))
        else $error("divider remainder out of range");

    // mean, estimate and deviation never exceed the largest possible sample
    a_mean_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_mean <= MEAN_MAX && r_est <= MEAN_MAX && r_dev <= MEAN_MAX))
        else $error("smoothed value above largest sample");

endmodule

/* rtl/rtt_timeout_estimator_top.sv */
// Round-trip timeout estimator. Each input transfer carries the microsecond
// parts of a send and a receive timestamp; each output transfer carries the
// round trip in whole ms, the retransmit timeout (4*deviation + estimate, ms),
// and the estimate, deviation and cumulative mean in ms with FRAC_BITS
// fraction bits. Input ready is low while an item is processed; the
// restoring divider forms the cumulative mean one quotient bit per cycle. A
// finished result waits in an output register, so the next item is accepted
// while it is unread. The sample count saturates at 2**COUNT_BITS-1.
module rtt_timeout_estimator_top #(
    parameter int unsigned COUNT_BITS = 32,
    parameter int unsigned FRAC_BITS  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [19:0] send_time_us, [39:20] recv_time_us
    input  logic [rte_pkg::SDATA_W-1:0] i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [9:0] rtt_ms, [22:10] timeout_ms, [40:23] est_out, [58:41] dev_out,
    // [76:59] mean_out, [79:77] zero
    output logic [rte_pkg::MDATA_W-1:0] o_m_tdata
);

    rte_pkg::t_cmd    cmd;
    rte_pkg::t_status status;

    rte_ctrl #(
        .VAL_W (rte_pkg::RTT_W + FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rte_dpath #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
